// File: rtl/assert_macros.svh
// Assertion macros shared by the spatializer RTL.
// Standalone header; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ssfs_pkg.sv
// Package for the sparse-tap stereo spatializer: payload structs, command codes,
// controller/datapath command and status structs. No dependencies.
package ssfs_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int MAX_TAPS_DEF      = 32;

  localparam int SAMPLE_W = 16;
  localparam int SLOT_W   = 5;
  localparam int DELAY_W  = 10;
  localparam int COUNT_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TAP_COUNT = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_LEFT_TAP  = 2'd1,
    CMD_RIGHT_TAP = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic [SLOT_W-1:0]           tap_slot;
    logic [DELAY_W-1:0]          tap_delay;
    logic signed [SAMPLE_W-1:0]  tap_weight;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       clipped;
  } out_t;

  typedef struct packed {
    logic clr_we;
    logic in_take;
    logic red_step;
    logic tap_we;
    logic hist_we;
    logic acc_clr;
    logic issue;
    logic sel_right;
    logic keep_left;
    logic out_load;
    logic wp_adv;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_ok;
    logic red_done;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } ctl_status_t;

endpackage

// File: rtl/ssfs_ctrl.sv
// Sequencer for the spatializer: clear pass, tap loads, per-channel MAC loops.
// Depends on ssfs_pkg; drives ssfs_datapath through ctl_cmd_t.
module ssfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ssfs_pkg::cmd_e        in_cmd_i,
  input  ssfs_pkg::ctl_status_t status_i,
  output ssfs_pkg::ctl_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_REDUCE = 9'b000000100,
    ST_SAMPLE = 9'b000001000,
    ST_LTAP   = 9'b000010000,
    ST_LWAIT  = 9'b000100000,
    ST_RTAP   = 9'b001000000,
    ST_RWAIT  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          if (in_cmd_i == ssfs_pkg::CMD_SAMPLE) begin
            state_d = ST_SAMPLE;
          end else if ((in_cmd_i == ssfs_pkg::CMD_LEFT_TAP ||
                        in_cmd_i == ssfs_pkg::CMD_RIGHT_TAP) && status_i.slot_ok) begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (status_i.red_done) begin
          cmd_o.tap_we = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_SAMPLE: begin
        cmd_o.hist_we = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d       = ST_LTAP;
      end
      ST_LTAP: begin
        if (status_i.issue_last) state_d = ST_LWAIT;
        else cmd_o.issue = 1'b1;
      end
      ST_LWAIT: begin
        if (!status_i.pipe_busy) begin
          cmd_o.keep_left = 1'b1;
          cmd_o.acc_clr   = 1'b1;
          state_d         = ST_RTAP;
        end
      end
      ST_RTAP: begin
        cmd_o.sel_right = 1'b1;
        if (status_i.issue_last) state_d = ST_RWAIT;
        else cmd_o.issue = 1'b1;
      end
      ST_RWAIT: begin
        cmd_o.sel_right = 1'b1;
        if (!status_i.pipe_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.wp_adv   = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/ssfs_datapath.sv
// Datapath for the spatializer: history ring, tap tables, MAC pipeline,
// rounding/saturation and result register. Depends on ssfs_pkg, assert_macros.svh.
`include "assert_macros.svh"

module ssfs_datapath #(
  parameter int HISTORY_DEPTH = ssfs_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_TAPS      = ssfs_pkg::MAX_TAPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssfs_pkg::in_t                     in_req_i,
  input  logic                              cfg_valid_i,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssfs_pkg::COUNT_W-1:0]      cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output ssfs_pkg::out_t                    out_rsp_o,
  input  ssfs_pkg::ctl_cmd_t                cmd_i,
  output ssfs_pkg::ctl_status_t             status_o
);

  localparam int HA    = $clog2(HISTORY_DEPTH);
  localparam int TA    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int NW    = (CW > ssfs_pkg::COUNT_W) ? CW : ssfs_pkg::COUNT_W;
  localparam int SW    = ((TA > ssfs_pkg::SLOT_W) ? TA : ssfs_pkg::SLOT_W) + 1;
  localparam int RW    = ((HA > ssfs_pkg::DELAY_W) ? HA : ssfs_pkg::DELAY_W) + 1;
  localparam int PW    = 2 * ssfs_pkg::SAMPLE_W;
  localparam int ACC_W = PW + TA + 1;
  localparam int Q_W   = ACC_W - ssfs_pkg::FRAC_BITS;
  localparam int TE_W  = HA + ssfs_pkg::SAMPLE_W;
  localparam int SH    = ssfs_pkg::SAMPLE_W - 1;

  // configuration
  logic [ssfs_pkg::COUNT_W-1:0] lcnt_q, rcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q <= '0;
      rcnt_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssfs_pkg::CFG_LEFT_TAP_COUNT: begin
          lcnt_q <= cfg_data_i;
        end
        ssfs_pkg::CFG_RIGHT_TAP_COUNT: begin
          rcnt_q <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  // latched request
  logic [SW-1:0]                      slot_ext;
  logic signed [ssfs_pkg::SAMPLE_W-1:0] smp_q, wgt_q;
  logic [RW-1:0]                      dly_q;
  logic [TA-1:0]                      slot_q;
  logic                               tsel_q;

  assign slot_ext = SW'(in_req_i.tap_slot);

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      smp_q  <= in_req_i.sample_in;
      wgt_q  <= in_req_i.tap_weight;
      dly_q  <= RW'(in_req_i.tap_delay);
      slot_q <= slot_ext[TA-1:0];
      tsel_q <= (in_req_i.cmd == ssfs_pkg::CMD_RIGHT_TAP);
    end else if (cmd_i.red_step) begin
      dly_q  <= dly_q - RW'(HISTORY_DEPTH);
    end
  end

  // tap tables
  logic [TE_W-1:0] ltab [MAX_TAPS];
  logic [TE_W-1:0] rtab [MAX_TAPS];
  logic [TE_W-1:0] tap_rd_q;
  logic [NW-1:0]   k_q;
  logic [TA-1:0]   k_idx;

  assign k_idx = k_q[TA-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && !tsel_q) ltab[slot_q] <= {dly_q[HA-1:0], wgt_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && tsel_q) rtab[slot_q] <= {dly_q[HA-1:0], wgt_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      if (cmd_i.sel_right) tap_rd_q <= rtab[k_idx];
      else tap_rd_q <= ltab[k_idx];
    end
  end

  // tap issue counter and channel limits
  logic [NW-1:0] lim_l, lim_r, lim;

  assign lim_l = (NW'(lcnt_q) > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : NW'(lcnt_q);
  assign lim_r = (NW'(rcnt_q) > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : NW'(rcnt_q);
  assign lim   = cmd_i.sel_right ? lim_r : lim_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.acc_clr) begin
      k_q <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + NW'(1);
    end
  end

  // history ring
  logic [ssfs_pkg::SAMPLE_W-1:0]        hist [HISTORY_DEPTH];
  logic [HA-1:0]                        wp_q, clr_q, hwa, rd_addr, tap_dly;
  logic [HA:0]                          diff;
  logic signed [ssfs_pkg::SAMPLE_W-1:0] hist_rd_q, w2_q;
  logic [ssfs_pkg::SAMPLE_W-1:0]        hwd;
  logic                                 v1_q, v2_q, v3_q;

  assign tap_dly = tap_rd_q[TE_W-1:ssfs_pkg::SAMPLE_W];
  assign diff    = {1'b0, wp_q} - {1'b0, tap_dly};
  assign rd_addr = diff[HA] ? HA'(diff + (HA+1)'(HISTORY_DEPTH)) : diff[HA-1:0];
  assign hwa     = cmd_i.clr_we ? clr_q : wp_q;
  assign hwd     = cmd_i.clr_we ? '0 : smp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we || cmd_i.hist_we) hist[hwa] <= hwd;
    if (v1_q) hist_rd_q <= hist[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + HA'(1);
      if (cmd_i.wp_adv) begin
        wp_q <= (wp_q == HA'(HISTORY_DEPTH - 1)) ? '0 : wp_q + HA'(1);
      end
    end
  end

  // MAC pipeline
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) w2_q <= tap_rd_q[ssfs_pkg::SAMPLE_W-1:0];
    if (v2_q) prod_q <= PW'(hist_rd_q) * PW'(w2_q);
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (v3_q) acc_q <= acc_q + ACC_W'(prod_q);
  end

  // truncate toward zero, saturate
  logic signed [ACC_W-1:0]              acc_b;
  logic [Q_W-1:0]                       q;
  logic                                 sat_clip;
  logic signed [ssfs_pkg::SAMPLE_W-1:0] sat_val;

  assign acc_b = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << ssfs_pkg::FRAC_BITS) - 1) : '0);
  assign q     = acc_b[ACC_W-1:ssfs_pkg::FRAC_BITS];
  assign sat_clip = !((&q[Q_W-1:SH]) || !(|q[Q_W-1:SH]));
  assign sat_val  = sat_clip ? (q[Q_W-1] ? ssfs_pkg::SAT_MIN : ssfs_pkg::SAT_MAX)
                             : q[ssfs_pkg::SAMPLE_W-1:0];

  // result register
  logic signed [ssfs_pkg::SAMPLE_W-1:0] left_q;
  logic                                 clipl_q, out_valid_q;
  ssfs_pkg::out_t                       out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep_left) begin
      left_q  <= sat_val;
      clipl_q <= sat_clip;
    end
    if (cmd_i.out_load) begin
      out_q.left_out  <= left_q;
      out_q.right_out <= sat_val;
      out_q.clipped   <= clipl_q | sat_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign status_o.clr_last   = (clr_q == HA'(HISTORY_DEPTH - 1));
  assign status_o.slot_ok    = (slot_ext < SW'(MAX_TAPS));
  assign status_o.red_done   = (dly_q < RW'(HISTORY_DEPTH));
  assign status_o.issue_last = (k_q == lim);
  assign status_o.pipe_busy  = v1_q | v2_q | v3_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  `ASSERT_IMPLIES(a_clr_drained, clk_i, rst_ni, cmd_i.acc_clr, !(v1_q || v2_q || v3_q), "accumulator cleared with MACs in flight")
  `ASSERT_IMPLIES(a_tap_reduced, clk_i, rst_ni, cmd_i.tap_we, dly_q < RW'(HISTORY_DEPTH), "tap delay stored before reduction")
  `ASSERT_IMPLIES(a_out_slot, clk_i, rst_ni, cmd_i.out_load, !out_valid_q || out_ready_i, "result overwritten before taken")

endmodule

// File: rtl/sparse_stereo_fir_spatializer_core.sv
// Sparse-tap stereo spatializer top: one stereo result per mono sample request.
// Sample request: history write, left MAC loop, right MAC loop, then result load once
// the output register is free; no new request is taken until the result is loaded.
// Tap-load request: delay reduced modulo HISTORY_DEPTH, then table write.
// One request at a time. After reset the history ring is cleared with in_ready_o low;
// configuration writes are taken at all times. Depends on ssfs_pkg, ssfs_ctrl, ssfs_datapath.
module sparse_stereo_fir_spatializer_core #(
  parameter int HISTORY_DEPTH = ssfs_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_TAPS      = ssfs_pkg::MAX_TAPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ssfs_pkg::in_t                  in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ssfs_pkg::out_t                 out_rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ssfs_pkg::COUNT_W-1:0]   cfg_data_i
);

  ssfs_pkg::ctl_cmd_t    cmd;
  ssfs_pkg::ctl_status_t status;

  assign cfg_ready_o = 1'b1;

  ssfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_req_i.cmd),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssfs_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_TAPS      (MAX_TAPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
